FILE: src/hpd_pkg.sv
// hpd_pkg: shared types, constants and helper functions of the half-precision divider
// no dependencies
`default_nettype none
package hpd_pkg;

    localparam int QuoBits = 26;   // 24 quotient bits plus guard and one extra

    // one stage of the divider chain
    typedef struct packed {
        logic        valid;
        logic        sign;
        logic [8:0]  exp;      // biased single exponent before normalization
        logic        zdiv;     // divisor zero
        logic        nan;      // zero over zero
        logic        zero;     // zero dividend
        logic [24:0] rem;      // partial remainder
        logic [23:0] dsr;      // divisor significand
        logic [QuoBits-1:0] quo;
    } t_stage;

    // widen a half pattern to a single pattern
    function automatic logic [31:0] widen_half(input logic [15:0] h);
        logic [4:0]  e;
        logic [9:0]  m;
        logic [7:0]  v;
        logic [9:0]  sm;
        logic        found;
        begin
            e = h[14:10];
            m = h[9:0];
            v = 8'd0;
            sm = 10'd0;
            found = 1'b0;
            if (e != 5'd0) begin
                widen_half = {h[15], 8'(e) + 8'd112, m, 13'd0};
            end else if (m == 10'd0) begin
                widen_half = {h[15], 31'd0};
            end else begin
                // leading one search over ten bits
                for (int i = 9; i >= 0; i--) begin
                    if (!found && m[i]) begin
                        found = 1'b1;
                        v = 8'(i) + 8'd103;
                        sm = 10'(m << (10 - i));
                    end
                end
                widen_half = {h[15], v, sm, 13'd0};
            end
        end
    endfunction

    // narrow a single pattern to a half pattern
    function automatic logic [15:0] narrow_single(input logic [31:0] x);
        logic [31:0] b;
        logic [7:0]  e;
        logic [22:0] m;
        logic [15:0] r;
        logic [23:0] t;
        begin
            b = x + 32'h0000_1000;
            e = b[30:23];
            m = b[22:0];
            r = {b[31], 15'd0};
            if (e > 8'd112)
                r = r | {1'b0, 5'(e - 8'd112), m[22:13]};
            if (e < 8'd113 && e > 8'd101) begin
                t = (24'h7FF000 + 24'(m)) >> (8'd125 - e);
                r = r | 16'((t + 24'd1) >> 1);
            end
            if (e > 8'd143)
                r = r | 16'h7FFF;
            narrow_single = r;
        end
    endfunction

endpackage
`default_nettype wire

FILE: src/half_precision_divider_core.sv
// half_precision_divider_core: top level, operand unpack, cell chain, round and narrow
// depends on hpd_pkg and hpd_cell
// stages from input accept to output valid: unpack, 26 cells, round
// throughput: one division per cycle; the whole chain advances while the output is free
// the chain stalls as a unit when the output register is full and not taken
// reset: synchronous active low, clears all valid bits; payload is not reset
`default_nettype none
module half_precision_divider_core
    import hpd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [15:0] i_dividend,
    input  wire logic [15:0] i_divisor,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [15:0]      o_quotient
);
    t_stage      r_head;
    t_stage      n_head;
    t_stage      chain [QuoBits+1];
    logic        adv;
    logic [31:0] wa;
    logic [31:0] wb;
    logic        r_valid;
    logic [15:0] r_quot;
    logic [15:0] n_quot;
    t_stage      tl;
    logic [8:0]  ex;
    logic [22:0] fr;
    logic        rb;
    logic        st;
    logic [23:0] mant;
    logic [8:0]  ef;
    logic [31:0] sres;

    assign adv     = !r_valid || i_ready;
    assign o_ready = adv;

    // widen operands and set up the first remainder
    always_comb begin
        wa = widen_half(i_dividend);
        wb = widen_half(i_divisor);
        n_head.valid = i_valid;
        n_head.sign  = wa[31] ^ wb[31];
        n_head.exp   = 9'(wa[30:23]) - 9'(wb[30:23]) + 9'd127;
        n_head.zdiv  = wb[30:0] == 31'd0;
        n_head.zero  = wa[30:0] == 31'd0;
        n_head.nan   = n_head.zdiv && n_head.zero;
        n_head.rem   = {1'b0, |wa[30:0], wa[22:0]};
        n_head.dsr   = {|wb[30:0], wb[22:0]};
        n_head.quo   = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head.valid <= 1'b0;
        end else if (adv) begin
            r_head <= n_head;
        end
    end

    assign chain[0] = r_head;

    // row of division cells
    for (genvar g = 0; g < QuoBits; g++) begin : g_cell
        hpd_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (adv),
            .i_stage (chain[g]),
            .o_stage (chain[g+1])
        );
    end

    // normalize, round to nearest even, narrow
    always_comb begin
        tl = chain[QuoBits];
        if (tl.quo[QuoBits-1]) begin
            mant = tl.quo[25:2];
            rb   = tl.quo[1];
            st   = tl.quo[0] || (tl.rem != 25'd0);
            ex   = tl.exp;
        end else begin
            mant = tl.quo[24:1];
            rb   = tl.quo[0];
            st   = tl.rem != 25'd0;
            ex   = tl.exp - 9'd1;
        end
        fr = mant[22:0];
        ef = ex;
        if (rb && (st || mant[0])) begin
            if (fr == 23'h7FFFFF) begin
                fr = 23'd0;
                ef = ex + 9'd1;
            end else begin
                fr = fr + 23'd1;
            end
        end
        if (tl.nan)
            sres = 32'hFFC0_0000;
        else if (tl.zdiv)
            sres = {tl.sign, 31'h7F80_0000};
        else if (tl.zero)
            sres = {tl.sign, 31'd0};
        else
            sres = {tl.sign, ef[7:0], fr};
        n_quot = narrow_single(sres);
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (adv) begin
            r_valid <= tl.valid;
        end
        if (adv)
            r_quot <= n_quot;
    end

    assign o_valid    = r_valid;
    assign o_quotient = r_quot;

`ifndef SYNTH
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_quotient))
        else $error("output word changed while stalled");
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("ready low with empty output");
    a_nan_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && tl.valid && tl.nan |=> o_quotient == 16'hFFFF)
        else $error("zero over zero did not give all ones");
`endif
endmodule
`default_nettype wire

FILE: src/hpd_cell.sv
// hpd_cell: one restoring division step of the divider chain
// depends on hpd_pkg
`default_nettype none
module hpd_cell
    import hpd_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_en,
    input  wire t_stage i_stage,
    output t_stage      o_stage
);
    t_stage     r_stage;
    t_stage     n_stage;
    logic [25:0] diff;

    // subtract the divisor and shift one quotient bit in
    always_comb begin
        n_stage = i_stage;
        diff = {1'b0, i_stage.rem} - {2'b0, i_stage.dsr};
        if (!diff[25]) begin
            n_stage.quo = {i_stage.quo[QuoBits-2:0], 1'b1};
            n_stage.rem = {diff[23:0], 1'b0};
        end else begin
            n_stage.quo = {i_stage.quo[QuoBits-2:0], 1'b0};
            n_stage.rem = {i_stage.rem[23:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;
endmodule
`default_nettype wire
